FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files of the rational reduce block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`endif

FILE: sv/rar_pkg.sv
// package for the rational reduce block: widths, opcodes, status codes, the shared work struct
// no dependencies
`default_nettype none
package rar_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int CmdWidth = 2;
   localparam int NumWidth = 32;
   localparam int DenWidth = 31;
   localparam int StatusWidth = 2;
   // wide enough for the exact products of two 31 bit magnitudes
   localparam int WideWidth = 64;
   localparam int QueueDepth = 2;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // classified item passed from front to back
   typedef struct packed {
      logic            err;
      cmd_type         cmd;
      logic            neg_a;
      logic            neg_b;
      logic [30:0]     mag_na;
      logic [30:0]     mag_da;
      logic [30:0]     mag_nb;
      logic [30:0]     mag_db;
   } work_type;
endpackage
`default_nettype wire

FILE: sv/rar_front.sv
// front: queues items, sign-normalizes operands and flags zero denominators and a zero divisor for divide
// depends on rar_pkg
`default_nettype none
module rar_front #(
   parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   output logic                          full,
   input  wire logic [1:0]               command,
   input  wire logic [OPERAND_WIDTH-1:0] num_a,
   input  wire logic [OPERAND_WIDTH-1:0] den_a,
   input  wire logic [OPERAND_WIDTH-1:0] num_b,
   input  wire logic [OPERAND_WIDTH-1:0] den_b,
   output logic                          q_valid,
   output rar_pkg::work_type             q_data,
   input  wire logic                     q_take
);
   localparam int Depth = rar_pkg::QueueDepth;
   localparam int PtrWidth = $clog2(Depth);

   rar_pkg::work_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   count_ff, count_in;
   logic                wr_en;
   rar_pkg::work_type   item;

   function automatic logic [30:0] mag_of(input logic [OPERAND_WIDTH-1:0] v, input logic flip);
      logic signed [31:0] s;
      begin
         s = 32'(signed'(v));
         if (flip) s = -s;
         mag_of = (s < 0) ? 31'(-s) : 31'(s);
      end
   endfunction

   always_comb begin
      logic sa, sb, za, zb, znb;
      sa  = den_a[OPERAND_WIDTH-1];
      sb  = den_b[OPERAND_WIDTH-1];
      za  = (den_a == '0);
      zb  = (den_b == '0);
      znb = (num_b == '0);
      item.cmd    = rar_pkg::cmd_type'(command);
      item.err    = za || zb || (item.cmd == rar_pkg::CMD_DIV && znb);
      // sign of each fraction after making its denominator positive
      item.neg_a  = (num_a[OPERAND_WIDTH-1] ^ sa) && (num_a != '0);
      item.neg_b  = (num_b[OPERAND_WIDTH-1] ^ sb) && (num_b != '0);
      item.mag_na = mag_of(num_a, 1'b0);
      item.mag_da = mag_of(den_a, 1'b0);
      item.mag_nb = mag_of(num_b, 1'b0);
      item.mag_db = mag_of(den_b, 1'b0);
   end

   assign full    = (count_ff == (PtrWidth+1)'(Depth));
   assign q_valid = (count_ff != '0);
   assign q_data  = mem_ff[rd_ptr_ff];
   assign wr_en   = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (q_take && q_valid) rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth-1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + (PtrWidth+1)'(wr_en) - (PtrWidth+1)'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= item;
   end

   `include "assert_macros.svh"
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= (PtrWidth+1)'(Depth))
   `ASSERT_IMPLY(a_no_take_empty, clock, reset, q_take, q_valid)
   `ASSERT_NEXT(a_push_counts, clock, reset, wr_en && !(q_take && q_valid), count_ff == $past(count_ff) + 1'b1)
endmodule
`default_nettype wire

FILE: sv/rar_divider.sv
// shared 64 bit restoring divider, one quotient bit per cycle
// depends on rar_pkg
`default_nettype none
module rar_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rar_pkg::WideWidth-1:0] dividend,
   input  wire logic [rar_pkg::WideWidth-1:0] divisor,
   output logic                              busy,
   output logic                              done,
   output logic [rar_pkg::WideWidth-1:0]     quotient,
   output logic [rar_pkg::WideWidth-1:0]     remainder
);
   localparam int W = rar_pkg::WideWidth;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic [W:0] trial;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `include "assert_macros.svh"
   `ASSERT_NEXT(a_done_after_last, clock, reset, busy_ff && cnt_ff == CW'(1) && !start, done_ff)
   `ASSERT_IMPLY(a_not_both, clock, reset, done_ff, !busy_ff || $past(start))
   `ASSERT_IMPLY(a_idle_count, clock, reset, !busy_ff, cnt_ff == '0)
endmodule
`default_nettype wire

FILE: sv/rar_back.sv
// back: lcm, cross products, euclidean gcd and reduction through a shared divider
// depends on rar_pkg and rar_divider
`default_nettype none
module rar_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire rar_pkg::work_type    q_data,
   output logic                      q_take,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [31:0]               result_num,
   output logic [30:0]               result_den,
   output logic [1:0]                status
);
   localparam int W = rar_pkg::WideWidth;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_G1     = 11'b00000000010,
      S_G1W    = 11'b00000000100,
      S_L1     = 11'b00000001000,
      S_L1W    = 11'b00000010000,
      S_MUL    = 11'b00000100000,
      S_SUM    = 11'b00001000000,
      S_G2W    = 11'b00010000000,
      S_R1W    = 11'b00100000000,
      S_R2W    = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   rar_pkg::work_type it_ff, it_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;       // gcd operands
   logic [W-1:0] ka_ff, ka_in, kb_ff, kb_in;   // lcm scale factors
   logic [W-1:0] mag_ff, mag_in, den_ff, den_in;
   logic         neg_ff, neg_in;
   logic [W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic         s1_ff, s1_in, s2_ff, s2_in;
   logic [1:0]   ph_ff, ph_in;
   logic         out_v_ff, out_v_in;
   logic [31:0]  onum_ff, onum_in;
   logic [30:0]  oden_ff, oden_in;
   logic [1:0]   ost_ff, ost_in;
   // status of the waiting result, kept apart from the working status
   logic [1:0]   res_st_ff, res_st_in;

   logic         d_start, d_busy, d_done;
   logic [W-1:0] d_dvd, d_dsr, d_quo, d_rem;

   rar_divider u_div (
      .clock(clock), .reset(reset), .start(d_start), .dividend(d_dvd), .divisor(d_dsr),
      .busy(d_busy), .done(d_done), .quotient(d_quo), .remainder(d_rem)
   );

   assign empty      = !out_v_ff;
   assign result_num = onum_ff;
   assign result_den = oden_ff;
   assign status     = res_st_ff;

   always_comb begin
      logic [W-1:0] t1, t2, sum;
      logic         r_neg;
      state_in = state_ff;
      it_in    = it_ff;
      a_in = a_ff; b_in = b_ff; ka_in = ka_ff; kb_in = kb_ff;
      mag_in = mag_ff; den_in = den_ff; neg_in = neg_ff;
      p1_in = p1_ff; p2_in = p2_ff; s1_in = s1_ff; s2_in = s2_ff;
      ph_in = ph_ff;
      out_v_in = out_v_ff; onum_in = onum_ff; oden_in = oden_ff; ost_in = ost_ff;
      res_st_in = res_st_ff;
      q_take  = 1'b0;
      d_start = 1'b0;
      d_dvd   = a_ff;
      d_dsr   = b_ff;
      t1 = '0; t2 = '0; sum = '0; r_neg = 1'b0;
      if (out_v_ff && pop) out_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               it_in  = q_data;
               if (q_data.err) begin
                  ost_in = rar_pkg::ST_ZERO_DEN;
                  state_in = S_DONE;
                  mag_in = '0; den_in = '0;
               end else if (q_data.cmd == rar_pkg::CMD_ADD || q_data.cmd == rar_pkg::CMD_SUB) begin
                  a_in = W'(q_data.mag_da);
                  b_in = W'(q_data.mag_db);
                  ph_in = 2'd0;
                  state_in = S_G1;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         // gcd of denominators, one remainder division per step
         S_G1: begin
            if (b_ff == '0) begin
               // a_ff holds gcd; lcm factors are db/g and da/g
               a_in = W'(it_ff.mag_db);
               b_in = a_ff;
               state_in = S_L1;
            end else begin
               d_start = 1'b1;
               state_in = S_G1W;
            end
         end
         S_G1W: begin
            if (d_done) begin
               a_in = b_ff;
               b_in = d_rem;
               state_in = S_G1;
            end
         end
         S_L1: begin
            d_start = 1'b1;
            state_in = S_L1W;
         end
         S_L1W: begin
            if (d_done) begin
               if (ph_ff == 2'd0) begin
                  ka_in = d_quo;                // db/g scales a
                  a_in  = W'(it_ff.mag_da);
                  ph_in = 2'd1;
                  state_in = S_L1;
               end else begin
                  kb_in = d_quo;                // da/g scales b
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // products on 31 bit magnitudes, registered before the sum
            if (it_ff.cmd == rar_pkg::CMD_ADD || it_ff.cmd == rar_pkg::CMD_SUB) begin
               p1_in = W'(it_ff.mag_na) * W'(ka_ff[31:0]);
               p2_in = W'(it_ff.mag_nb) * W'(kb_ff[31:0]);
               s1_in = it_ff.neg_a;
               s2_in = it_ff.neg_b ^ (it_ff.cmd == rar_pkg::CMD_SUB);
               den_in = W'(it_ff.mag_da) * W'(ka_ff[31:0]);
            end else if (it_ff.cmd == rar_pkg::CMD_MUL) begin
               p1_in = W'(it_ff.mag_na) * W'(it_ff.mag_nb);
               p2_in = '0;
               s1_in = it_ff.neg_a ^ it_ff.neg_b;
               s2_in = 1'b0;
               den_in = W'(it_ff.mag_da) * W'(it_ff.mag_db);
            end else begin
               p1_in = W'(it_ff.mag_na) * W'(it_ff.mag_db);
               p2_in = '0;
               s1_in = it_ff.neg_a ^ it_ff.neg_b;
               s2_in = 1'b0;
               den_in = W'(it_ff.mag_da) * W'(it_ff.mag_nb);
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            t1 = s1_ff ? -p1_ff : p1_ff;
            t2 = s2_ff ? -p2_ff : p2_ff;
            sum = t1 + t2;
            r_neg = sum[W-1];
            neg_in = r_neg;
            mag_in = r_neg ? -sum : sum;
            if (sum == '0) begin
               ost_in = rar_pkg::ST_OK;
               mag_in = '0;
               den_in = W'(1);
               neg_in = 1'b0;
               state_in = S_DONE;
            end else begin
               a_in = r_neg ? -sum : sum;
               b_in = den_ff;
               state_in = S_G2W;
               d_start = 1'b0;
               ph_in = 2'd2;
            end
         end
         // gcd of result magnitude and denominator
         S_G2W: begin
            if (ph_ff == 2'd2) begin
               if (b_ff == '0) begin
                  d_dvd = mag_ff;
                  d_dsr = a_ff;
                  d_start = 1'b1;
                  b_in = a_ff;
                  state_in = S_R1W;
               end else begin
                  d_start = 1'b1;
                  ph_in = 2'd3;
               end
            end else if (d_done) begin
               a_in = b_ff;
               b_in = d_rem;
               ph_in = 2'd2;
            end
         end
         S_R1W: begin
            if (d_done) begin
               mag_in = d_quo;
               d_dvd = den_ff;
               d_dsr = b_ff;
               d_start = 1'b1;
               state_in = S_R2W;
            end
         end
         S_R2W: begin
            if (d_done) begin
               den_in = d_quo;
               state_in = S_DONE;
               ost_in = rar_pkg::ST_OK;
               if (d_quo > W'(32'h7FFF_FFFF)) ost_in = rar_pkg::ST_OVERFLOW;
               else if (neg_ff && mag_ff > W'(32'h8000_0000)) ost_in = rar_pkg::ST_OVERFLOW;
               else if (!neg_ff && mag_ff > W'(32'h7FFF_FFFF)) ost_in = rar_pkg::ST_OVERFLOW;
            end
         end
         S_DONE: begin
            if (!out_v_ff) begin
               out_v_in = 1'b1;
               res_st_in = ost_ff;
               if (ost_ff == rar_pkg::ST_OK) begin
                  onum_in = neg_ff ? 32'(-mag_ff) : mag_ff[31:0];
                  oden_in = den_ff[30:0];
               end else begin
                  onum_in = '0;
                  oden_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      it_ff <= it_in; a_ff <= a_in; b_ff <= b_in; ka_ff <= ka_in; kb_ff <= kb_in;
      mag_ff <= mag_in; den_ff <= den_in; neg_ff <= neg_in;
      p1_ff <= p1_in; p2_ff <= p2_in; s1_ff <= s1_in; s2_ff <= s2_in; ph_ff <= ph_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ost_ff <= ost_in;
      res_st_ff <= res_st_in;
   end

   `include "assert_macros.svh"
   `ASSERT_ALWAYS(a_onehot, clock, reset, $onehot(state_ff))
   `ASSERT_IMPLY(a_start_idle_div, clock, reset, d_start, !d_busy)
   `ASSERT_IMPLY(a_err_zero, clock, reset, out_v_ff && res_st_ff != rar_pkg::ST_OK, onum_ff == '0 && oden_ff == '0)
endmodule
`default_nettype wire

FILE: sv/rational_arith_reduce.sv
// rational_arith_reduce: add, subtract, multiply or divide two signed fractions,
// result reduced to lowest terms with a positive denominator.
// input channel: queue style, an item is taken when req_push is high and req_full low.
// a two entry queue sits between the classifying front and the arithmetic back,
// so the front keeps taking items while the back works, until the queue is full.
// result channel: queue style, the result is on rsp_ ports while rsp_empty is low,
// and is taken when rsp_pop is high. one result per item, in order.
// processing: an error item goes straight to the result; otherwise every division runs
// on the shared divider and every euclid step is one division, with a gcd of the
// denominators and two scale divisions first for add and subtract, then a gcd on
// the result and two reduction divisions; a zero result skips these last steps.
// the back works on one item at a time and takes the next item only after it is
// through with the last one.
// a stalled receiver holds the result; the back waits and the queue fills,
// then req_full rises. reset (synchronous) empties the queue and the result.
`default_nettype none
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic [1:0]               req_command,
   input  wire logic [OPERAND_WIDTH-1:0] req_num_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_den_a,
   input  wire logic [OPERAND_WIDTH-1:0] req_num_b,
   input  wire logic [OPERAND_WIDTH-1:0] req_den_b,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output logic [31:0]                   rsp_result_num,
   output logic [30:0]                   rsp_result_den,
   output logic [1:0]                    rsp_status
);
   logic              q_valid, q_take;
   rar_pkg::work_type q_data;

   rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .command(req_command), .num_a(req_num_a), .den_a(req_den_a),
      .num_b(req_num_b), .den_b(req_den_b),
      .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
   );

   rar_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
      .empty(rsp_empty), .pop(rsp_pop), .result_num(rsp_result_num),
      .result_den(rsp_result_den), .status(rsp_status)
   );
endmodule
`default_nettype wire

FILE: verif/tb_rational_arith_reduce.sv
// testbench for rational_arith_reduce: directed and random fraction arithmetic items,
// every result checked against a predictor of the exact reduced fraction
// depends on rar_pkg and the rational_arith_reduce rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arith_reduce;
   localparam int OpW = rar_pkg::OperandWidthDefault;
   localparam int StallLimit = 200000;

   typedef struct {
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0]  status;
   } fraction_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_command = rar_pkg::CMD_ADD;
   logic [OpW-1:0]    req_num_a = '0;
   logic [OpW-1:0]    req_den_a = '0;
   logic [OpW-1:0]    req_num_b = '0;
   logic [OpW-1:0]    req_den_b = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [31:0]       rsp_result_num;
   logic [30:0]       rsp_result_den;
   logic [1:0]        rsp_status;

   fraction_result_type expected_fractions[$];
   int                error_count = 0;
   int                items_sent = 0;
   int                results_seen = 0;
   int                idle_cycles = 0;
   int                op_counts[4] = '{0, 0, 0, 0};
   bit                allow_idle = 1'b1;
   bit                hold_off = 1'b0;

   rational_arith_reduce DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_command(req_command),
      .req_num_a(req_num_a), .req_den_a(req_den_a),
      .req_num_b(req_num_b), .req_den_b(req_den_b),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_result_num(rsp_result_num), .rsp_result_den(rsp_result_den),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic fraction_result_type predict_fraction(logic [1:0] op, logic [OpW-1:0] fa,
         logic [OpW-1:0] fb, logic [OpW-1:0] fc, logic [OpW-1:0] fd);
      fraction_result_type r;
      longint na, da, nb, db, rn;
      logic [63:0] rd, mag, g, lcm;
      na = longint'($signed(fa));
      da = longint'($signed(fb));
      nb = longint'($signed(fc));
      db = longint'($signed(fd));
      r = '{num: '0, den: '0, status: rar_pkg::ST_ZERO_DEN};
      if (da == 0 || db == 0 || (op == rar_pkg::CMD_DIV && nb == 0)) return r;
      if (da < 0) begin
         na = -na;
         da = -da;
      end
      if (db < 0) begin
         nb = -nb;
         db = -db;
      end
      case (op)
         rar_pkg::CMD_ADD, rar_pkg::CMD_SUB: begin
            lcm = (da / gcd64(da, db)) * db;
            rn = (op == rar_pkg::CMD_ADD) ? na * longint'(lcm / da) + nb * longint'(lcm / db)
                                          : na * longint'(lcm / da) - nb * longint'(lcm / db);
            rd = lcm;
         end
         rar_pkg::CMD_MUL: begin
            rn = na * nb;
            rd = da * db;
         end
         default: begin
            rn = (nb < 0) ? -(na * db) : na * db;
            rd = (nb < 0) ? da * -nb : da * nb;
         end
      endcase
      r.status = rar_pkg::ST_OK;
      if (rn == 0) begin
         r.den = 31'd1;
         return r;
      end
      mag = (rn < 0) ? -rn : rn;
      g = gcd64(mag, rd);
      mag = mag / g;
      rd = rd / g;
      if (rd > 64'h7FFF_FFFF || (rn < 0 && mag > 64'h8000_0000)
            || (rn >= 0 && mag > 64'h7FFF_FFFF)) begin
         r.status = rar_pkg::ST_OVERFLOW;
         return r;
      end
      r.num = (rn < 0) ? -mag[31:0] : mag[31:0];
      r.den = rd[30:0];
      return r;
   endfunction

   task automatic send_item(logic [1:0] op, logic [OpW-1:0] fa, logic [OpW-1:0] fb,
         logic [OpW-1:0] fc, logic [OpW-1:0] fd);
      int gap;
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_command <= op;
      req_num_a <= fa;
      req_den_a <= fb;
      req_num_b <= fc;
      req_den_b <= fd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_fractions.push_back(predict_fraction(op, fa, fb, fc, fd));
      items_sent++;
      op_counts[op]++;
   endtask

   task automatic end_burst();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [OpW-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return OpW'($urandom_range(0, 8));
         1: return -OpW'($urandom_range(1, 8));
         2: return {1'b1, {(OpW-1){1'b0}}};
         3: return {1'b0, {(OpW-1){1'b1}}};
         4: return OpW'($urandom_range(0, 255)) - OpW'(128);
         default: return OpW'($urandom);
      endcase
   endfunction

   // result side: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            if (expected_fractions.size() == 0) begin
               $error("result with no item outstanding: num %0d", $signed(rsp_result_num));
               error_count++;
            end else begin
               fraction_result_type e;
               e = expected_fractions.pop_front();
               if (rsp_result_num !== e.num) begin
                  $error("result_num expected %0d actual %0d", $signed(e.num),
                     $signed(rsp_result_num));
                  error_count++;
               end
               if (rsp_result_den !== e.den) begin
                  $error("result_den expected %0d actual %0d", e.den, rsp_result_den);
                  error_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  error_count++;
               end
            end
            results_seen++;
         end
      end
   end

   // receiver: random pop stalls, plus a long hold-off on request
   int pop_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_stall <= 0;
      end else begin
         if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            rsp_pop <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            pop_stall <= $urandom_range(0, 15);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog: cycles with nothing accepted on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic drain();
      while (expected_fractions.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [OpW-1:0] mx, mn, one, neg1, zero;
      mx = {1'b0, {(OpW-1){1'b1}}};
      mn = {1'b1, {(OpW-1){1'b0}}};
      one = OpW'(1);
      neg1 = '1;
      zero = '0;
      for (int op = 0; op < 4; op++) begin
         send_item(2'(op), OpW'(3), OpW'(4), OpW'(5), OpW'(6));
         send_item(2'(op), mn, mn, mn, mn);
         send_item(2'(op), mx, neg1, mn, one);
         send_item(2'(op), mn, mx, mx, mn);
      end
      send_item(rar_pkg::CMD_ADD, one, zero, one, OpW'(2));
      send_item(rar_pkg::CMD_MUL, one, OpW'(2), one, zero);
      send_item(rar_pkg::CMD_DIV, one, OpW'(2), zero, OpW'(3));
      send_item(rar_pkg::CMD_SUB, OpW'(5), OpW'(7), OpW'(5), OpW'(7));
      send_item(rar_pkg::CMD_MUL, zero, neg1, OpW'(9), OpW'(4));
      send_item(rar_pkg::CMD_DIV, -OpW'(2), OpW'(4), neg1, neg1);
      send_item(rar_pkg::CMD_MUL, mn, one, mn, one);
      send_item(rar_pkg::CMD_ADD, mx, 16'h7ffe, mx, 16'h7ffd);
      end_burst();
      drain();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_item(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
            rand_operand(), rand_operand());
      end_burst();
   endtask

   // receiver holds off long enough for the input queue to fill up
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (12000) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(8);
      join
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(350);
      test_backpressure();
      drain();
      test_random(250);
      allow_idle = 1'b0;
      test_random(120);
      drain();
      repeat (50) @(posedge clock);
      $display("sent %0d items (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
         items_sent, op_counts[0], op_counts[1], op_counts[2], op_counts[3], results_seen);
      $display("covered operand extremes, zero and error cases, stalls and a full input queue");
      if (error_count == 0 && expected_fractions.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
